/* rtl/u8sd_pkg.sv */
// ---------------------------------------------------------------------------
// u8sd_pkg
// Shared widths and byte-class constants for the UTF-8 stream decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8sd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CP_W    = 31;
  localparam int unsigned LEFT_W  = 3;
  localparam int unsigned OUT_W   = 32;   // code point padded to whole bytes

  // Lead patterns (prefix bits) and payload masks per sequence length
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_PAT   = 8'h80;
  localparam logic [7:0] ASCII_MASK = 8'h80;
  localparam logic [7:0] L2_MASK    = 8'hE0;
  localparam logic [7:0] L2_PAT     = 8'hC0;
  localparam logic [7:0] L3_MASK    = 8'hF0;
  localparam logic [7:0] L3_PAT     = 8'hE0;
  localparam logic [7:0] L4_MASK    = 8'hF8;
  localparam logic [7:0] L4_PAT     = 8'hF0;
  localparam logic [7:0] L5_MASK    = 8'hFC;
  localparam logic [7:0] L5_PAT     = 8'hF8;
  localparam logic [7:0] L6_MASK    = 8'hFE;
  localparam logic [7:0] L6_PAT     = 8'hFC;

  localparam logic [7:0] L2_DATA    = 8'h1F;
  localparam logic [7:0] L3_DATA    = 8'h0F;
  localparam logic [7:0] L4_DATA    = 8'h07;
  localparam logic [7:0] L5_DATA    = 8'h03;
  localparam logic [7:0] L6_DATA    = 8'h01;
  localparam logic [7:0] CONT_DATA  = 8'h3F;

endpackage

/* rtl/utf8_stream_decoder_top.sv */
// ---------------------------------------------------------------------------
// utf8_stream_decoder_top
// Byte-serial UTF-8 decoder: 1..6 byte forms, 31-bit code points, per-string
// end marker on the byte flagged with tlast.
// ---------------------------------------------------------------------------
//  channel  | dir | tdata                  | tuser    | tlast
//  ---------+-----+------------------------+----------+-----------------------
//  s_*      | in  | [7:0] in_byte          | -        | in_last (string end)
//  m_*      | out | [30:0] code_point, [31]0 | has_char | is_end
//
//  One byte per cycle sustained while m_* accepts results. A byte is held in the
//  input register, and its result is registered into the output register as the
//  byte retires. Both stages are the throughput limit: one transaction each
//  per clock. Bytes that yield no result (leads, mid-sequence continuations,
//  dropped bytes) retire without touching the output register, so they pass
//  even while m_* is stalled. rst is synchronous and clears valids and the
//  decoder state (no sequence pending).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_stream_decoder_top (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // in_last
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [30:0] code_point, [31] zero pad
  output logic        m_tuser,   // [0] has_char
  output logic        m_tlast    // is_end
);

  // input register
  logic                              in_valid;
  logic [u8sd_pkg::BYTE_W-1:0]       in_byte;
  logic                              in_last;

  // decoder state
  logic [u8sd_pkg::LEFT_W-1:0]       bytes_left;
  logic [u8sd_pkg::LEFT_W-1:0]       bytes_left_next;
  logic [u8sd_pkg::CP_W-1:0]         partial_value;
  logic [u8sd_pkg::CP_W-1:0]         partial_value_next;

  // decode results for the byte in the input register
  logic                              done;
  logic [u8sd_pkg::CP_W-1:0]         value;
  logic [u8sd_pkg::CP_W-1:0]         shifted;
  logic                              emit;
  logic                              out_free;
  logic                              retire;

  assign out_free = !m_tvalid || m_tready;
  assign emit     = done || in_last;
  // a byte with no result never waits on the master side
  assign retire   = in_valid && (!emit || out_free);
  assign s_tready = !in_valid || retire;

  assign shifted = {partial_value[u8sd_pkg::CP_W-7:0], in_byte[5:0]};

  always_comb begin
    done               = 1'b0;
    value              = '0;
    bytes_left_next    = bytes_left;
    partial_value_next = partial_value;

    if ((in_byte & u8sd_pkg::CONT_MASK) == u8sd_pkg::CONT_PAT) begin
      // continuation: extend pending sequence, stray ones are dropped
      if (bytes_left != '0) begin
        bytes_left_next = bytes_left - u8sd_pkg::LEFT_W'(1);
        if (bytes_left == u8sd_pkg::LEFT_W'(1)) begin
          done               = 1'b1;
          value              = shifted;
          partial_value_next = '0;
        end else begin
          partial_value_next = shifted;
        end
      end
    end else begin
      // any other byte abandons a pending sequence and starts fresh
      bytes_left_next    = '0;
      partial_value_next = '0;
      if ((in_byte & u8sd_pkg::ASCII_MASK) == 8'h00) begin
        done  = 1'b1;
        value = u8sd_pkg::CP_W'(in_byte);
      end else if ((in_byte & u8sd_pkg::L2_MASK) == u8sd_pkg::L2_PAT) begin
        bytes_left_next    = u8sd_pkg::LEFT_W'(1);
        partial_value_next = u8sd_pkg::CP_W'(in_byte & u8sd_pkg::L2_DATA);
      end else if ((in_byte & u8sd_pkg::L3_MASK) == u8sd_pkg::L3_PAT) begin
        bytes_left_next    = u8sd_pkg::LEFT_W'(2);
        partial_value_next = u8sd_pkg::CP_W'(in_byte & u8sd_pkg::L3_DATA);
      end else if ((in_byte & u8sd_pkg::L4_MASK) == u8sd_pkg::L4_PAT) begin
        bytes_left_next    = u8sd_pkg::LEFT_W'(3);
        partial_value_next = u8sd_pkg::CP_W'(in_byte & u8sd_pkg::L4_DATA);
      end else if ((in_byte & u8sd_pkg::L5_MASK) == u8sd_pkg::L5_PAT) begin
        bytes_left_next    = u8sd_pkg::LEFT_W'(4);
        partial_value_next = u8sd_pkg::CP_W'(in_byte & u8sd_pkg::L5_DATA);
      end else if ((in_byte & u8sd_pkg::L6_MASK) == u8sd_pkg::L6_PAT) begin
        bytes_left_next    = u8sd_pkg::LEFT_W'(5);
        partial_value_next = u8sd_pkg::CP_W'(in_byte & u8sd_pkg::L6_DATA);
      end
      // 0xFE / 0xFF fall through: dropped
    end

    // end of string flushes anything incomplete
    if (in_last) begin
      bytes_left_next    = '0;
      partial_value_next = '0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // decoder state advances as each byte retires
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left    <= '0;
      partial_value <= '0;
    end else if (retire) begin
      bytes_left    <= bytes_left_next;
      partial_value <= partial_value_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= retire && emit;
    end
    if (retire && emit) begin
      m_tdata <= {1'b0, value};
      m_tuser <= done;
      m_tlast <= in_last;
    end
  end

endmodule

/* rtl/u8sd_checker.sv */
// ---------------------------------------------------------------------------
// u8sd_checker
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8sd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // result without a character must be an end marker with zero data
  a_marker_only: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && (m_tdata == '0))
    else $error("result with no character is not a clean end marker");

  // code point stays within 31 bits
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[31] == 1'b0))
    else $error("code point pad bit set");

  // an accepted ASCII byte whose next cycle finds the output free shows up
  // as a character on the cycle after
  a_ascii_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tdata[7] == 1'b0) ##1 (!m_tvalid || m_tready)
      |=> m_tvalid && m_tuser)
    else $error("ASCII byte did not produce a character in time");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // nothing valid right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind utf8_stream_decoder_top u8sd_checker u_u8sd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

/* tb/tb_utf8_stream_decoder_top.sv */
// ---------------------------------------------------------------------------
// tb_utf8_stream_decoder_top
// Self-checking bench for the UTF-8 stream decoder. A directed set of byte
// strings covers every lead form, the code point extremes, stray and dropped
// bytes, interrupted sequences and string ends with and without a character.
// Random strings follow, mostly well-formed with random payload and some
// truncated sequences and noise bytes. Both sides idle and stall at random.
// One long sink hold backs the decoder up into its input. A scoreboard
// tracks the decoder state, predicts each output transaction and compares
// it field by field in arrival order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_utf8_stream_decoder_top;

  localparam int unsigned RAND_BYTES      = 650;
  localparam int unsigned SINK_HOLD_CYCLES = 160;
  localparam int unsigned STALL_LIMIT     = 2000;  // cycles with no handshake at all
  localparam int unsigned DRAIN_CYCLES    = 10;

  // One output transaction as the decoder should present it
  typedef struct packed {
    logic [u8sd_pkg::CP_W-1:0] code_point;
    logic                      has_char;
    logic                      is_end;
  } char_result_t;

  // Tracks the decoder state from the accepted bytes and keeps the queue of
  // output transactions still owed by the DUT.
  class code_point_tracker;
    logic [u8sd_pkg::LEFT_W-1:0] cont_left;   // continuation bytes still owed
    logic [u8sd_pkg::CP_W-1:0]   cp_acc;      // code point bits gathered so far
    char_result_t      owed_chars[$];
    int unsigned       mismatches;
    int unsigned       chars_seen;
    int unsigned       ends_seen;
    int unsigned       bytes_seen;
    int unsigned       strings_seen;

    function new();
      cont_left    = '0;
      cp_acc       = '0;
      mismatches   = 0;
      chars_seen   = 0;
      ends_seen    = 0;
      bytes_seen   = 0;
      strings_seen = 0;
    endfunction

    function void note_byte(logic [u8sd_pkg::BYTE_W-1:0] b, logic last);
      logic                      done;
      logic [u8sd_pkg::CP_W-1:0] cp;
      char_result_t              r;
      done = 1'b0;
      cp   = '0;
      bytes_seen++;
      if ((b & u8sd_pkg::CONT_MASK) == u8sd_pkg::CONT_PAT) begin
        // continuation: ignored unless a sequence is open
        if (cont_left != 0) begin
          cp_acc    = {cp_acc[u8sd_pkg::CP_W-7:0], b[5:0]};
          cont_left = cont_left - u8sd_pkg::LEFT_W'(1);
          if (cont_left == 0) begin
            done   = 1'b1;
            cp     = cp_acc;
            cp_acc = '0;
          end
        end
      end else begin
        // any other byte abandons an open sequence and starts over
        cont_left = '0;
        cp_acc    = '0;
        if ((b & u8sd_pkg::ASCII_MASK) == 8'h00) begin
          done = 1'b1;
          cp   = u8sd_pkg::CP_W'(b);
        end else if ((b & u8sd_pkg::L2_MASK) == u8sd_pkg::L2_PAT) begin
          cont_left = 3'd1;
          cp_acc    = u8sd_pkg::CP_W'(b & u8sd_pkg::L2_DATA);
        end else if ((b & u8sd_pkg::L3_MASK) == u8sd_pkg::L3_PAT) begin
          cont_left = 3'd2;
          cp_acc    = u8sd_pkg::CP_W'(b & u8sd_pkg::L3_DATA);
        end else if ((b & u8sd_pkg::L4_MASK) == u8sd_pkg::L4_PAT) begin
          cont_left = 3'd3;
          cp_acc    = u8sd_pkg::CP_W'(b & u8sd_pkg::L4_DATA);
        end else if ((b & u8sd_pkg::L5_MASK) == u8sd_pkg::L5_PAT) begin
          cont_left = 3'd4;
          cp_acc    = u8sd_pkg::CP_W'(b & u8sd_pkg::L5_DATA);
        end else if ((b & u8sd_pkg::L6_MASK) == u8sd_pkg::L6_PAT) begin
          cont_left = 3'd5;
          cp_acc    = u8sd_pkg::CP_W'(b & u8sd_pkg::L6_DATA);
        end
        // 0xFE / 0xFF fall through: dropped
      end
      if (last) begin
        cont_left = '0;
        cp_acc    = '0;
        strings_seen++;
      end
      if (done || last) begin
        r.code_point = cp;
        r.has_char   = done;
        r.is_end     = last;
        owed_chars.push_back(r);
      end
    endfunction

    function void check_char(logic [u8sd_pkg::OUT_W-1:0] tdata, logic tuser, logic tlast);
      char_result_t want;
      if (owed_chars.size() == 0) begin
        mismatches++;
        $display("%0t ERROR: unexpected transaction, expected none, actual cp=%h char=%b end=%b",
                 $time, tdata, tuser, tlast);
        return;
      end
      want = owed_chars.pop_front();
      if (want.has_char) chars_seen++;
      if (want.is_end) ends_seen++;
      if (tdata !== {1'b0, want.code_point} || tuser !== want.has_char ||
          tlast !== want.is_end) begin
        mismatches++;
        $display("%0t ERROR: expected cp=%h char=%b end=%b, actual cp=%h char=%b end=%b",
                 $time, {1'b0, want.code_point}, want.has_char, want.is_end,
                 tdata, tuser, tlast);
      end
    endfunction

    function int unsigned owed();
      return owed_chars.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] in_byte
  logic        s_tlast;   // in_last
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [30:0] code_point, [31] zero pad
  logic        m_tuser;   // [0] has_char
  logic        m_tlast;   // is_end

  code_point_tracker tracker = new();

  // idle knobs shared between the stimulus and the sink process
  bit          src_steady;     // sender offers back to back
  bit          sink_steady;    // sink starts no new random stalls
  bit          sink_hold_req;  // sink holds off for SINK_HOLD_CYCLES
  int unsigned bytes_sent;

  utf8_stream_decoder_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Gap length: random, now and then a long one
  function automatic int unsigned gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Both handshakes are sampled at the rising edge. Input bytes are noted
  // before the output is checked so that the order never matters.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) tracker.note_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) tracker.check_char(m_tdata, m_tuser, m_tlast);
    end
  end

  // Sink: random stalls, or a long hold-off on request so that the output
  // register fills and the decoder pushes back on its input.
  initial begin : sink_proc
    int unsigned stall_left;
    stall_left = 0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        m_tready = 1'b0;
      end else if (sink_hold_req) begin
        m_tready = 1'b0;
        repeat (SINK_HOLD_CYCLES - 1) @(negedge clk);
        sink_hold_req = 1'b0;
      end else if (stall_left != 0) begin
        m_tready   = 1'b0;
        stall_left = stall_left - 1;
      end else if (!sink_steady && $urandom_range(0, 99) < 25) begin
        m_tready   = 1'b0;
        stall_left = gap_len() - 1;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  // Watchdog: ends the run if no transaction moves on either side for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet = quiet + 1;
    end
    $display("%0t ERROR: no transaction for %0d cycles, %0d results outstanding",
             $time, STALL_LIMIT, tracker.owed());
    $display("Simulation FAILED");
    $finish;
  end

  // Offer one byte; called and returning at a falling edge. valid stays high
  // across back-to-back bytes.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned idle;
    if (!src_steady && $urandom_range(0, 99) < 30) begin
      idle     = gap_len();
      s_tvalid = 1'b0;
      repeat (idle) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tlast  = last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // One random string: mostly whole characters with random payload bits,
  // some sequences cut short and some raw noise bytes. tlast on the final byte.
  task automatic send_random_string();
    logic [7:0]  seq[$];
    int unsigned n_chars;
    int unsigned roll;
    int unsigned len;
    int unsigned keep;
    n_chars = $urandom_range(1, 10);
    repeat (n_chars) begin
      roll = $urandom_range(0, 99);
      if (roll < 85) begin
        len = ($urandom_range(0, 99) < 40) ? 1 : $urandom_range(2, 6);
        if (roll < 70) keep = len - 1;
        else keep = (len > 1) ? $urandom_range(0, len - 2) : 0;
        case (len)
          1: seq.push_back(8'($urandom_range(0, 127)));
          2: seq.push_back(u8sd_pkg::L2_PAT | (8'($urandom) & u8sd_pkg::L2_DATA));
          3: seq.push_back(u8sd_pkg::L3_PAT | (8'($urandom) & u8sd_pkg::L3_DATA));
          4: seq.push_back(u8sd_pkg::L4_PAT | (8'($urandom) & u8sd_pkg::L4_DATA));
          5: seq.push_back(u8sd_pkg::L5_PAT | (8'($urandom) & u8sd_pkg::L5_DATA));
          default: seq.push_back(u8sd_pkg::L6_PAT | (8'($urandom) & u8sd_pkg::L6_DATA));
        endcase
        repeat (keep) seq.push_back(u8sd_pkg::CONT_PAT | (8'($urandom) & u8sd_pkg::CONT_DATA));
      end else begin
        seq.push_back(8'($urandom_range(0, 255)));
      end
    end
    foreach (seq[i]) send_byte(seq[i], i == seq.size() - 1);
  endtask

  initial begin : stimulus
    // {last, byte}
    logic [8:0] directed_seq[$];
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tlast       = 1'b0;
    src_steady    = 1'b0;
    sink_steady   = 1'b0;
    sink_hold_req = 1'b0;
    bytes_sent    = 0;
    rst           = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed strings:
    //   2-byte lead cut off by ASCII 0x00, then ASCII top 0x7F
    //   stray continuation with nothing open
    //   whole 2, 3 (ends the string), 4 byte characters
    //   smallest 5-byte pattern, largest 6-byte pattern (full 31 bits)
    //   0xFF abandoning an open 3-byte sequence
    //   0xFE alone on the last byte: end marker only
    //   open 4-byte lead replaced by a 2-byte lead that ends the string
    directed_seq = '{9'h0C3, 9'h000, 9'h07F, 9'h0BF, 9'h0C2, 9'h0A9,
                     9'h0E2, 9'h082, 9'h1AC,
                     9'h0F0, 9'h09F, 9'h098, 9'h080,
                     9'h0F8, 9'h080, 9'h080, 9'h080, 9'h080,
                     9'h0FD, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF,
                     9'h0E2, 9'h0FF, 9'h1FE, 9'h0F0, 9'h1C2};
    foreach (directed_seq[i]) send_byte(directed_seq[i][7:0], directed_seq[i][8]);

    // Back-pressure: sink holds off while ASCII bytes are offered back to back
    sink_hold_req = 1'b1;
    src_steady    = 1'b1;
    repeat (23) send_byte(8'($urandom_range(0, 127)), 1'b0);
    send_byte(8'($urandom_range(0, 127)), 1'b1);

    // Random strings; some run with no idling on either side
    while (bytes_sent < directed_seq.size() + RAND_BYTES) begin
      src_steady  = ($urandom_range(0, 99) < 15);
      sink_steady = src_steady;
      send_random_string();
    end

    // Drain: sink starts no new stalls, wait for every owed transaction
    s_tvalid    = 1'b0;
    src_steady  = 1'b1;
    sink_steady = 1'b1;
    while (tracker.owed() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d bytes in %0d strings: %0d characters and %0d end markers checked.",
             tracker.bytes_seen, tracker.strings_seen, tracker.chars_seen, tracker.ends_seen);
    $display("Random stalls on both sides plus one %0d-cycle sink hold-off.", SINK_HOLD_CYCLES);
    if (tracker.mismatches == 0 && tracker.owed() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", tracker.mismatches, tracker.owed());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
